/* hw/rtl/stdu_pkg.sv */
// Shared types and constants for the swizzled indexed texture decode unit.
// Used by the output queue and the top level; no dependencies.
`default_nettype none

package stdu_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int MAX_DIM           = 1024;
  localparam int MAX_PITCH         = 4096;
  localparam int BLOCK_H           = 8;
  localparam int BLOCK_BYTES       = 128;

  // output queue: power of two, holds two words in flight plus two queued
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_TEXEL   = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDX4,
    MODE_IDX8,
    MODE_IDX16,
    MODE_IDX32
  } idx_mode_t;

  typedef enum logic [2:0] {
    CFG_INDEX_MODE,
    CFG_SWIZZLED,
    CFG_ROW_PITCH,
    CFG_WIDTH_LOG2,
    CFG_PALETTE_SIZE
  } cfg_reg_t;

  typedef struct packed {
    logic [9:0] px;
    logic [9:0] py;
    logic       bad;
    logic       last;
  } pix_t;

  typedef struct packed {
    logic [31:0] color;
    logic [9:0]  py;
    logic [9:0]  px;
    logic        bad;
    logic        last;
  } out_word_t;

  // up to two words pushed per cycle
  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  w0;
    out_word_t  w1;
  } fifo_push_t;

endpackage

`default_nettype wire

/* hw/rtl/swizzled_indexed_texture_decode_unit.sv */
// Indexed texture decoder with 16x8 block unswizzle and palette lookup.
// Path: a texel byte's positions and palette reads are registered, then queued.
// Throughput: one word per cycle in while the queue has room, one result per cycle out
// while out_tready is high; the palette RAM reads both pixels of a 4-bit byte at once.
// Reset: synchronous, active low; registers to defaults, counters and queue to zero.
// Palette RAM contents are not cleared and are undefined until written.
`default_nettype none

module swizzled_indexed_texture_decode_unit #(
  parameter int PALETTE_DEPTH = stdu_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: palette_slot[7:0], palette_color[39:8], data_byte[47:40]
  input  wire logic [47:0] in_tdata,
  // in_tuser: opcode[0], first_byte[1]
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // out_tdata: pixel_x[9:0], pixel_y[19:10], red[27:20], green[35:28], blue[43:36],
  // alpha[51:44], zero pad[55:52]
  output      logic [55:0] out_tdata,
  // out_tuser: index_invalid[0]
  output      logic [0:0]  out_tuser,
  output      logic        out_tlast,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready
);
  import stdu_pkg::*;

  localparam int PAW  = $clog2(PALETTE_DEPTH);
  localparam int RW   = OUT_LVL_W + 1;

  // configuration
  idx_mode_t   mode_r;
  logic        swz_r;
  logic [12:0] pitch_r;
  logic [3:0]  wlog_r;
  logic [8:0]  psize_r;

  // position counters
  logic [11:0] col_r,  col_nxt;
  logic [10:0] row_r,  row_nxt;
  logic [6:0]  bib_r,  bib_nxt;
  logic [7:0]  bcol_r, bcol_nxt;
  logic [7:0]  brow_r, brow_nxt;
  logic [23:0] acc_r,  acc_nxt;

  // read stage
  logic [1:0]  b_cnt_r, b_cnt_nxt;
  pix_t        b_res_r [2];
  pix_t        res_c   [2];
  logic [1:0]  cnt_c;

  logic            accept;
  logic            is_texel;
  logic [7:0]      slot;
  logic [31:0]     pcolor;
  logic [7:0]      dbyte;
  logic [31:0]     idx0, idx1;
  logic [31:0]     limit;
  logic            pal_we;
  logic [31:0]     rd_a, rd_b;
  fifo_push_t      push;
  out_word_t       head;
  logic [OUT_LVL_W-1:0] level;
  logic [RW-1:0]   room_need;

  assign slot     = in_tdata[7:0];
  assign pcolor   = in_tdata[39:8];
  assign dbyte    = in_tdata[47:40];
  assign is_texel = (in_tuser[0] == OP_TEXEL);
  assign accept   = in_tvalid && in_tready;

  // worst case: words queued, words in the read stage, and two more from this one
  assign room_need = RW'(level) + RW'(b_cnt_r) + RW'(2);
  assign in_tready = (room_need <= RW'(OUT_DEPTH));
  assign cfg_ready = 1'b1;

  assign limit = (32'(psize_r) > 32'(PALETTE_DEPTH)) ? 32'(PALETTE_DEPTH) : 32'(psize_r);
  assign pal_we = accept && !is_texel && (32'(slot) < 32'(PALETTE_DEPTH));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDX8;
      swz_r   <= 1'b0;
      pitch_r <= 13'd16;
      wlog_r  <= 4'd0;
      psize_r <= 9'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INDEX_MODE:   mode_r  <= idx_mode_t'(cfg_data[1:0]);
        CFG_SWIZZLED:     swz_r   <= cfg_data[0];
        CFG_ROW_PITCH:    pitch_r <= cfg_data;
        CFG_WIDTH_LOG2:   wlog_r  <= cfg_data[3:0];
        CFG_PALETTE_SIZE: psize_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // byte position, index assembly, counter advance
  always_comb begin
    logic        first;
    logic [11:0] col_c;
    logic [10:0] row_c;
    logic [6:0]  bib_c;
    logic [7:0]  bcol_c;
    logic [7:0]  brow_c;
    logic [23:0] acc_c;
    logic [12:0] pitch_eff;
    logic [8:0]  blocks;
    logic [11:0] bx;
    logic [10:0] by;
    logic [10:0] w;
    logic [12:0] byte_width;
    logic        in_range;
    logic        two;
    logic [1:0]  lane;
    logic        top_lane;
    logic [23:0] acc_base;
    logic [31:0] idx_wide;
    logic [12:0] col_inc;
    logic [8:0]  bcol_inc;

    first  = is_texel && in_tuser[1];
    col_c  = first ? '0 : col_r;
    row_c  = first ? '0 : row_r;
    bib_c  = first ? '0 : bib_r;
    bcol_c = first ? '0 : bcol_r;
    brow_c = first ? '0 : brow_r;
    acc_c  = first ? '0 : acc_r;

    if (pitch_r == 13'd0) begin
      pitch_eff = 13'd1;
    end else if (pitch_r > 13'(MAX_PITCH)) begin
      pitch_eff = 13'(MAX_PITCH);
    end else begin
      pitch_eff = pitch_r;
    end
    blocks = (pitch_eff[12:4] == 9'd0) ? 9'd1 : pitch_eff[12:4];

    bx = swz_r ? {bcol_c, bib_c[3:0]} : col_c;
    by = swz_r ? {brow_c, bib_c[6:4]} : row_c;

    w = (wlog_r >= 4'($clog2(MAX_DIM))) ? 11'(MAX_DIM) : (11'd1 << wlog_r);
    case (mode_r)
      MODE_IDX4:  byte_width = 13'((14'(w) + 14'd1) >> 1);
      MODE_IDX8:  byte_width = 13'(w);
      MODE_IDX16: byte_width = 13'(w) << 1;
      MODE_IDX32: byte_width = 13'(w) << 2;
      default:    byte_width = 13'(w);
    endcase
    in_range = is_texel && ({1'b0, bx} < byte_width) && (by < 11'(MAX_DIM));

    two      = ({bx, 1'b1} < {2'b00, w});
    lane     = (mode_r == MODE_IDX16) ? {1'b0, bx[0]} : bx[1:0];
    top_lane = (mode_r == MODE_IDX16) ? (lane == 2'd1) : (lane == 2'd3);
    acc_base = (lane == 2'd0) ? '0 : acc_c;
    idx_wide = {8'h00, acc_base} | (32'(dbyte) << {lane, 3'b000});

    cnt_c          = 2'd0;
    idx0           = 32'(dbyte);
    idx1           = 32'(dbyte[7:4]);
    acc_nxt        = acc_c;
    res_c[0].px    = bx[9:0];
    res_c[0].py    = by[9:0];
    res_c[0].last  = 1'b1;
    res_c[1].px    = {bx[8:0], 1'b1};
    res_c[1].py    = by[9:0];
    res_c[1].last  = 1'b1;

    if (in_range) begin
      case (mode_r)
        MODE_IDX4: begin
          idx0          = 32'(dbyte[3:0]);
          res_c[0].px   = {bx[8:0], 1'b0};
          res_c[0].last = !two;
          cnt_c         = two ? 2'd2 : 2'd1;
        end
        MODE_IDX8: begin
          cnt_c = 2'd1;
        end
        MODE_IDX16, MODE_IDX32: begin
          idx0        = idx_wide;
          res_c[0].px = (mode_r == MODE_IDX16) ? bx[10:1] : bx[11:2];
          if (top_lane) begin
            cnt_c   = 2'd1;
            acc_nxt = '0;
          end else begin
            acc_nxt = idx_wide[23:0];
          end
        end
        default: ;
      endcase
    end

    res_c[0].bad = (idx0 >= limit);
    res_c[1].bad = (idx1 >= limit);

    // counters move for every texel byte, dropped or not
    col_nxt  = col_c;
    row_nxt  = row_c;
    bib_nxt  = bib_c;
    bcol_nxt = bcol_c;
    brow_nxt = brow_c;
    col_inc  = {1'b0, col_c} + 13'd1;
    bcol_inc = {1'b0, bcol_c} + 9'd1;
    if (swz_r) begin
      if (bib_c == 7'(BLOCK_BYTES - 1)) begin
        bib_nxt = '0;
        if (bcol_inc >= blocks) begin
          bcol_nxt = '0;
          if (brow_c < 8'(MAX_DIM / BLOCK_H)) begin
            brow_nxt = brow_c + 8'd1;
          end
        end else begin
          bcol_nxt = bcol_inc[7:0];
        end
      end else begin
        bib_nxt = bib_c + 7'd1;
      end
    end else begin
      if (col_inc >= pitch_eff) begin
        col_nxt = '0;
        if (row_c < 11'(MAX_DIM)) begin
          row_nxt = row_c + 11'd1;
        end
      end else begin
        col_nxt = col_inc[11:0];
      end
    end
  end

  assign b_cnt_nxt = accept ? cnt_c : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      bib_r   <= '0;
      bcol_r  <= '0;
      brow_r  <= '0;
      acc_r   <= '0;
      b_cnt_r <= 2'd0;
    end else begin
      b_cnt_r <= b_cnt_nxt;
      if (accept && is_texel) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        bib_r  <= bib_nxt;
        bcol_r <= bcol_nxt;
        brow_r <= brow_nxt;
        acc_r  <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_res_r[0] <= res_c[0];
    b_res_r[1] <= res_c[1];
  end

  // palette: written by palette words, read for both pixels of a texel byte
  stdu_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk       (clk),
    .wr_en     (pal_we),
    .wr_addr   (PAW'(32'(slot))),
    .wr_data   (pcolor),
    .rd_addr_a (PAW'(idx0)),
    .rd_data_a (rd_a),
    .rd_addr_b (PAW'(idx1)),
    .rd_data_b (rd_b)
  );

  // read data lands here in the cycle after the lookup and goes straight to the queue
  assign push.cnt      = b_cnt_r;
  assign push.w0.color = b_res_r[0].bad ? 32'd0 : rd_a;
  assign push.w0.py    = b_res_r[0].py;
  assign push.w0.px    = b_res_r[0].px;
  assign push.w0.bad   = b_res_r[0].bad;
  assign push.w0.last  = b_res_r[0].last;
  assign push.w1.color = b_res_r[1].bad ? 32'd0 : rd_b;
  assign push.w1.py    = b_res_r[1].py;
  assign push.w1.px    = b_res_r[1].px;
  assign push.w1.bad   = b_res_r[1].bad;
  assign push.w1.last  = b_res_r[1].last;

  stdu_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop_ready (out_tready),
    .pop_valid (out_tvalid),
    .pop_word  (head),
    .level     (level)
  );

  assign out_tdata = {4'b0000, head.color, head.py, head.px};
  assign out_tuser = head.bad;
  assign out_tlast = head.last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(level) <= 32'(OUT_DEPTH))
    else $error("result queue over capacity");

  a_palette_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser[0] == OP_PALETTE)) |=> (b_cnt_r == 2'd0))
    else $error("palette word produced a result");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (b_cnt_r == 2'd2) |-> (!b_res_r[0].last && b_res_r[1].last))
    else $error("two-pixel byte with wrong last marking");

  a_bad_is_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[51:20] == 32'd0))
    else $error("invalid index with nonzero color");

endmodule

`default_nettype wire

/* hw/rtl/stdu_ram.sv */
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module stdu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output      logic [WIDTH-1:0]         rd_data_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output      logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

`default_nettype wire

/* hw/rtl/stdu_out_fifo.sv */
// Result queue: takes zero, one or two words per cycle, hands out one while pop_ready is high.
// Depends on stdu_pkg.
`default_nettype none

module stdu_out_fifo (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire stdu_pkg::fifo_push_t            push,
  input  wire logic                            pop_ready,
  output      logic                            pop_valid,
  output      stdu_pkg::out_word_t             pop_word,
  output      logic [stdu_pkg::OUT_LVL_W-1:0]  level
);
  import stdu_pkg::*;

  out_word_t              slots_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_r;
  logic [OUT_PTR_W-1:0]   rd_ptr_r;
  logic [OUT_LVL_W-1:0]   level_r;
  logic [OUT_PTR_W-1:0]   wr_ptr_inc;
  logic                   pop;

  assign pop_valid  = (level_r != '0);
  assign pop        = pop_valid && pop_ready;
  assign pop_word   = slots_r[rd_ptr_r];
  assign level      = level_r;
  assign wr_ptr_inc = OUT_PTR_W'(wr_ptr_r + 1'b1);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      slots_r[wr_ptr_r] <= push.w0;
    end
    if (push.cnt == 2'd2) begin
      slots_r[wr_ptr_inc] <= push.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= OUT_PTR_W'(wr_ptr_r + OUT_PTR_W'(push.cnt));
      rd_ptr_r <= OUT_PTR_W'(rd_ptr_r + OUT_PTR_W'(pop));
      level_r  <= OUT_LVL_W'(level_r + OUT_LVL_W'(push.cnt) - OUT_LVL_W'(pop));
    end
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking bench for swizzled_indexed_texture_decode_unit: palette writes and texel
// bytes go in, decoded pixels are predicted in a scoreboard class and compared word by word.
// Depends on stdu_pkg and the decode unit RTL only.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stdu_pkg::*;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;

  typedef struct packed {
    logic [9:0] px;
    logic [9:0] py;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       bad;
    logic       last;
  } decoded_pixel_t;

  // Predicts the pixels each accepted word produces and checks them in order.
  class texel_decode_model;
    idx_mode_t      mode;
    bit             swz;
    bit [12:0]      pitch;
    bit [3:0]       wlog2;
    bit [8:0]       pal_size;
    bit [31:0]      colors [PALETTE_DEPTH_DEF];
    int unsigned    col, row, blk_byte, blk_col, blk_row;
    bit [23:0]      acc;
    decoded_pixel_t pixels_due [$];
    int             errors;

    function new();
      mode     = MODE_IDX8;
      swz      = 1'b0;
      pitch    = 13'd16;
      wlog2    = 4'd0;
      pal_size = 9'd0;
      col = 0; row = 0; blk_byte = 0; blk_col = 0; blk_row = 0;
      acc      = '0;
      errors   = 0;
    endfunction

    function void write_reg(cfg_reg_t r, bit [12:0] v);
      case (r)
        CFG_INDEX_MODE:   mode = idx_mode_t'(v[1:0]);
        CFG_SWIZZLED:     swz = v[0];
        CFG_ROW_PITCH:    pitch = v;
        CFG_WIDTH_LOG2:   wlog2 = v[3:0];
        CFG_PALETTE_SIZE: pal_size = v[8:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_pitch();
      int unsigned p;
      p = pitch;
      if (p == 0) p = 1;
      if (p > MAX_PITCH) p = MAX_PITCH;
      return p;
    endfunction

    function void push_pixel(int unsigned px, int unsigned py, bit [31:0] idx, bit last);
      int unsigned    lim;
      decoded_pixel_t p;
      bit [31:0]      color;
      lim   = (pal_size > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : pal_size;
      p.bad = (idx >= lim);
      color = p.bad ? 32'h0 : colors[idx[7:0]];
      p.px    = px[9:0];
      p.py    = py[9:0];
      p.red   = color[7:0];
      p.green = color[15:8];
      p.blue  = color[23:16];
      p.alpha = color[31:24];
      p.last  = last;
      pixels_due.push_back(p);
    endfunction

    function void accept_word(bit op, bit [7:0] slot, bit [31:0] color, bit [7:0] data,
                              bit first);
      int unsigned bx, by, w, bw, nbytes, lane, blocks;
      bit          two;
      bit [31:0]   idx;
      if (op == OP_PALETTE) begin
        colors[slot] = color;
        return;
      end
      if (first) begin
        col = 0; row = 0; blk_byte = 0; blk_col = 0; blk_row = 0;
        acc = '0;
      end
      if (swz) begin
        bx = blk_col * 16 + (blk_byte & 15);
        by = blk_row * BLOCK_H + (blk_byte >> 4);
      end else begin
        bx = col;
        by = row;
      end
      w = 1 << wlog2;
      if (w > MAX_DIM) w = MAX_DIM;
      case (mode)
        MODE_IDX4:  nbytes = 1;
        MODE_IDX8:  nbytes = 1;
        MODE_IDX16: nbytes = 2;
        default:    nbytes = 4;
      endcase
      bw = (mode == MODE_IDX4) ? (w + 1) / 2 : w * nbytes;
      if (bx < bw && by < MAX_DIM) begin
        case (mode)
          MODE_IDX4: begin
            two = (2 * bx + 1) < w;
            push_pixel(2 * bx, by, {28'h0, data[3:0]}, !two);
            if (two) push_pixel(2 * bx + 1, by, {28'h0, data[7:4]}, 1'b1);
          end
          MODE_IDX8: push_pixel(bx, by, {24'h0, data}, 1'b1);
          default: begin
            // wide index: low lanes collect, top lane emits
            lane = bx & (nbytes - 1);
            if (lane == 0) acc = '0;
            idx = {8'h0, acc} | (32'(data) << (8 * lane));
            if (lane == nbytes - 1) begin
              push_pixel(bx / nbytes, by, idx, 1'b1);
              acc = '0;
            end else begin
              acc = idx[23:0];
            end
          end
        endcase
      end
      if (swz) begin
        blocks = eff_pitch() / 16;
        if (blocks == 0) blocks = 1;
        blk_byte++;
        if (blk_byte >= BLOCK_BYTES) begin
          blk_byte = 0;
          blk_col++;
          if (blk_col >= blocks) begin
            blk_col = 0;
            if (blk_row < MAX_DIM / BLOCK_H) blk_row++;
          end
        end
      end else begin
        col++;
        if (col >= eff_pitch()) begin
          col = 0;
          if (row < MAX_DIM) row++;
        end
      end
    endfunction

    function string fmt(decoded_pixel_t p);
      return $sformatf("x=%0d y=%0d rgba=%02x_%02x_%02x_%02x bad=%0b last=%0b",
                       p.px, p.py, p.red, p.green, p.blue, p.alpha, p.bad, p.last);
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR @%0t: %s", $time, msg);
    endtask

    task check_pixel(decoded_pixel_t got);
      decoded_pixel_t want;
      string          diffs;
      if (pixels_due.size() == 0) begin
        report({"pixel with none expected: ", fmt(got)});
        return;
      end
      want  = pixels_due.pop_front();
      diffs = "";
      if (got.px    !== want.px)    diffs = {diffs, " pixel_x"};
      if (got.py    !== want.py)    diffs = {diffs, " pixel_y"};
      if (got.red   !== want.red)   diffs = {diffs, " red"};
      if (got.green !== want.green) diffs = {diffs, " green"};
      if (got.blue  !== want.blue)  diffs = {diffs, " blue"};
      if (got.alpha !== want.alpha) diffs = {diffs, " alpha"};
      if (got.bad   !== want.bad)   diffs = {diffs, " index_invalid"};
      if (got.last  !== want.last)  diffs = {diffs, " last_of_run"};
      if (diffs != "")
        report({"mismatch on", diffs, ": want ", fmt(want), " got ", fmt(got)});
    endtask

    function int pending();
      return pixels_due.size();
    endfunction
  endclass

  typedef struct {
    idx_mode_t mode;
    bit        swz;
    int        pitch;
    int        wl;
    int        ps;
    int        n;
    int        sidle;
    int        rstall;
    bit        hold;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        cfg_valid;
  logic        cfg_ready;

  texel_decode_model model = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  swizzled_indexed_texture_decode_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: check accepted words, then pick the next tready
  always @(posedge clk) begin
    decoded_pixel_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.px    = out_tdata[9:0];
      got.py    = out_tdata[19:10];
      got.red   = out_tdata[27:20];
      got.green = out_tdata[35:28];
      got.blue  = out_tdata[43:36];
      got.alpha = out_tdata[51:44];
      got.bad   = out_tuser[0];
      got.last  = out_tlast;
      model.check_pixel(got);
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(bit op, bit [7:0] slot, bit [31:0] color, bit [7:0] data,
                           bit first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {data, color, slot};
    in_tuser  <= {first, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    model.accept_word(op, slot, color, data, first);
  endtask

  task automatic send_texel(bit [7:0] data, bit first);
    send_word(OP_TEXEL, 8'($urandom_range(255)), $urandom, data, first);
  endtask

  task automatic send_color(bit [7:0] slot, bit [31:0] color);
    send_word(OP_PALETTE, slot, color, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // wait out every expected pixel plus the pipeline tail
  task automatic drain();
    in_tvalid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(idx_mode_t mode, bit swz, int pitch, int wl, int ps);
    cfg_reg_t    regs [5];
    int unsigned vals [5];
    regs = '{CFG_INDEX_MODE, CFG_SWIZZLED, CFG_ROW_PITCH, CFG_WIDTH_LOG2, CFG_PALETTE_SIZE};
    vals = '{mode, swz, pitch, wl, ps};
    drain();
    foreach (regs[i]) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i][12:0];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      model.write_reg(regs[i], vals[i][12:0]);
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly runs of random texel bytes, plus palette updates and stray bytes
  task automatic run_phase(phase_t ph);
    int sent, len, pick;
    bit fresh;
    configure(ph.mode, ph.swz, ph.pitch, ph.wl, ph.ps);
    send_idle_pct = ph.sidle;
    stall_pct <= ph.rstall;
    if (ph.hold) hold_req <= hold_req + 1;
    sent  = 0;
    fresh = 1'b0;  // first run keeps counters left by the previous settings
    while (sent < ph.n) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_color(8'($urandom_range(255)), $urandom);
        sent++;
      end else if (pick < 16) begin
        send_texel(8'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end else begin
        if (ph.swz) len = $urandom_range(300, 32);
        else len = model.eff_pitch() * $urandom_range(3, 1);
        if (len > 40) len = $urandom_range(40, 16);
        for (int i = 0; i < len; i++) begin
          if (i == 0) begin
            send_texel(8'($urandom_range(255)), fresh && ($urandom_range(9) != 0));
          end else begin
            send_texel(8'($urandom_range(255)), $urandom_range(49) == 0);
          end
        end
        sent += len;
      end
      fresh = 1'b1;
    end
  endtask

  phase_t phases [10];

  initial begin
    rst_n      <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= {1'b0, OP_PALETTE};
    in_tvalid  <= 1'b0;
    out_tready <= 1'b0;
    cfg_index  <= CFG_INDEX_MODE;
    cfg_data   <= '0;
    cfg_valid  <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every palette entry gets a color before any lookup can reach it
    for (int s = 0; s < PALETTE_DEPTH_DEF; s++) send_color(8'(s), $urandom);

    // directed: odd last byte of a 4-bit row, then a byte past the width
    configure(MODE_IDX4, 1'b0, 16, 0, 256);
    send_texel(8'hF0, 1'b1);
    send_texel(8'h0F, 1'b0);
    configure(MODE_IDX4, 1'b0, 2, 2, 16);
    send_texel(8'h00, 1'b1);
    send_texel(8'hFF, 1'b0);
    send_texel(8'hA5, 1'b0);
    send_texel(8'h5A, 1'b0);
    // palette extremes, index at and above the palette size
    configure(MODE_IDX8, 1'b0, 16, 10, 16);
    send_color(8'h00, 32'h0000_0000);
    send_color(8'hFF, 32'hFFFF_FFFF);
    send_texel(8'h0F, 1'b1);
    send_texel(8'h10, 1'b0);
    send_texel(8'hFF, 1'b0);
    // 16-bit indices, swizzled with zero pitch, oversized palette size
    configure(MODE_IDX16, 1'b1, 0, 1, 511);
    send_texel(8'h05, 1'b1);
    send_texel(8'h00, 1'b0);
    send_texel(8'hFF, 1'b0);
    send_texel(8'hFF, 1'b0);
    // 32-bit indices, pitch and width beyond their caps
    configure(MODE_IDX32, 1'b0, 8191, 15, 256);
    send_texel(8'h01, 1'b1);
    repeat (2) send_texel(8'h00, 1'b0);
    send_texel(8'h00, 1'b0);
    repeat (3) send_texel(8'h00, 1'b0);
    send_texel(8'h80, 1'b0);

    phases = '{
      '{MODE_IDX4,  1'b0,   8,  4, 256,  25,  0,  0, 1'b0},
      '{MODE_IDX8,  1'b0,  24,  4, 200,  25, 52,  0, 1'b0},
      '{MODE_IDX16, 1'b1,  32,  3, 256,  35,  0, 52, 1'b0},
      '{MODE_IDX32, 1'b0,  20,  2, 511,  25,  6,  6, 1'b0},
      '{MODE_IDX4,  1'b1,  40,  5, 100,  35, 52, 52, 1'b0},
      '{MODE_IDX8,  1'b1,   0, 10, 256,  25,  0,  0, 1'b0},
      '{MODE_IDX16, 1'b0, 8191, 15,  0,  15,  6,  6, 1'b0},
      '{MODE_IDX4,  1'b0,   1,  0,   1,  15,  0, 52, 1'b0},
      '{MODE_IDX4,  1'b0,  16,  5, 256,  30,  0,  0, 1'b1},
      '{MODE_IDX32, 1'b1, 4096, 10, 256,  25, 52,  0, 1'b0}
    };
    foreach (phases[p]) run_phase(phases[p]);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (model.pending() == 0 && model.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
